@@ design/cbz_pkg.sv @@
// Shared constants and types for the curve sampler / arc follower.
// No dependencies.
package cbz_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 32;
    localparam int LEN_W      = 32;
    localparam int TOT_W      = LEN_W + IDX_W + 1;
    localparam int COEF_W     = 41;
    localparam int NUM_W      = 64;

    localparam logic OP_BUILD  = 1'b0;
    localparam logic OP_INTERP = 1'b1;

    // one row of the point memory
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [LEN_W-1:0]          len;
    } t_entry;

    // per-axis polynomial coefficients
    typedef struct packed {
        logic signed [COORD_W-1:0] a0;
        logic signed [COEF_W-1:0]  b;
        logic signed [COEF_W-1:0]  c;
        logic signed [COEF_W-1:0]  d;
    } t_coef;

endpackage

@@ design/cbz_if.sv @@
// Handshake interfaces for the request and response words.
// Depends on nothing; widths are those of the word fields.
interface cbz_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [31:0] p0_x;
    logic signed [31:0] p0_y;
    logic signed [31:0] p1_x;
    logic signed [31:0] p1_y;
    logic signed [31:0] p2_x;
    logic signed [31:0] p2_y;
    logic signed [31:0] p3_x;
    logic signed [31:0] p3_y;
    logic [7:0]         point_count;
    logic [31:0]        distance;

    modport source (output valid, op, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                    point_count, distance, input ready);
    modport sink   (input valid, op, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                    point_count, distance, output ready);
endinterface

interface cbz_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [6:0]         segment_index;
    logic [31:0]        total_length;

    modport source (output valid, pos_x, pos_y, segment_index, total_length, input ready);
    modport sink   (input valid, pos_x, pos_y, segment_index, total_length, output ready);
endinterface

@@ design/cbz_div.sv @@
// Iterative unsigned divider, one quotient bit per cycle.
// Uses cbz_pkg for the dividend and divisor widths.
module cbz_div import cbz_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [LEN_W-1:0] i_divisor,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot,
    output logic [LEN_W-1:0] o_rem
);
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [NUM_W-1:0]  r_q;
    logic [LEN_W-1:0]  r_rem;
    logic [LEN_W-1:0]  r_den;
    logic [LEN_W:0]    trial;
    logic              fits;

    assign trial = {r_rem, r_q[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= fits ? LEN_W'(trial - {1'b0, r_den}) : trial[LEN_W-1:0];
                r_q    <= {r_q[NUM_W-2:0], fits};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule

@@ design/cbz_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
// Uses cbz_pkg for the length width.
module cbz_sqrt import cbz_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [2*LEN_W-1:0] i_value,
    output logic               o_done,
    output logic [LEN_W-1:0]   o_root
);
    localparam int STEP_W = $clog2(LEN_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [STEP_W-1:0]  r_step;
    logic [2*LEN_W-1:0] r_v;
    logic [LEN_W+1:0]   r_rem;
    logic [LEN_W-1:0]   r_root;
    logic [LEN_W+2:0]   t;
    logic [LEN_W+2:0]   trial;
    logic               fits;

    assign t     = {r_rem[LEN_W:0], r_v[2*LEN_W-1 -: 2]};
    assign trial = {1'b0, r_root, 2'b01};
    assign fits  = t >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_v    <= i_value;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rem  <= fits ? (LEN_W+2)'(t - trial) : t[LEN_W+1:0];
                r_root <= {r_root[LEN_W-2:0], fits};
                r_v    <= {r_v[2*LEN_W-3:0], 2'b00};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(LEN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

@@ design/curve_sample_and_arc_follow.sv @@
// Top level: sequencer, point/length memory and output register.
// Depends on cbz_pkg, cbz_if, cbz_div and cbz_sqrt.
//
// Usage:
//   i_req carries one request word; op 0 builds a sampled curve from four
//   control points and a point count, op 1 looks up the point at a travelled
//   distance along the last built curve. o_rsp returns one word per request:
//   total length for a build, point and segment index for a lookup.
//   One request is worked on at a time; i_req.ready is high while idle.
//   Build: each sample point takes two 64-step divisions, one 32-step square
//   root and multiplies. Lookup: one memory read per stored segment walked,
//   plus the two interpolating divisions. The iterative divider and the
//   square root unit take most of the time.
//   The result sits in an output register; a new request is accepted while
//   it waits, and the block stalls before writing the next result until the
//   receiver has taken the previous one.
//   Reset empties the curve: a lookup before any build returns point zero.
module curve_sample_and_arc_follow import cbz_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cbz_in_if.sink    i_req,
    cbz_out_if.source o_rsp
);
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_COEF   = 5'd1;
    localparam logic [4:0] S_MAC_B  = 5'd2;
    localparam logic [4:0] S_MAC_C  = 5'd3;
    localparam logic [4:0] S_MAC_D  = 5'd4;
    localparam logic [4:0] S_MUL_I  = 5'd5;
    localparam logic [4:0] S_PREP   = 5'd6;
    localparam logic [4:0] S_DIV    = 5'd7;
    localparam logic [4:0] S_DIV_W  = 5'd8;
    localparam logic [4:0] S_RND    = 5'd9;
    localparam logic [4:0] S_ADD    = 5'd10;
    localparam logic [4:0] S_SQ_X   = 5'd11;
    localparam logic [4:0] S_SQ_Y   = 5'd12;
    localparam logic [4:0] S_SQRT   = 5'd13;
    localparam logic [4:0] S_SQRT_W = 5'd14;
    localparam logic [4:0] S_WRITE  = 5'd15;
    localparam logic [4:0] S_I_RD0  = 5'd16;
    localparam logic [4:0] S_I_PREV = 5'd17;
    localparam logic [4:0] S_I_RD   = 5'd18;
    localparam logic [4:0] S_I_CHK  = 5'd19;
    localparam logic [4:0] S_L_MUL  = 5'd20;
    localparam logic [4:0] S_OUT    = 5'd21;

    localparam int FAC_W = 2 * IDX_W;

    function automatic t_coef mk_coef(input logic signed [COORD_W-1:0] a0,
                                      input logic signed [COORD_W-1:0] a1,
                                      input logic signed [COORD_W-1:0] a2,
                                      input logic signed [COORD_W-1:0] a3);
        logic signed [COEF_W-1:0] e0, e1, e2, e3, ta, tc;
        t_coef res;
        e0     = COEF_W'(a0);
        e1     = COEF_W'(a1);
        e2     = COEF_W'(a2);
        e3     = COEF_W'(a3);
        ta     = 41'sd3 * e1 + e0;
        res.a0 = a0;
        res.b  = 41'sd9 * e1;
        tc     = ((e2 - 41'sd3 * e3) - ta) * 41'sd3 - res.b;
        res.c  = tc;
        res.d  = (e2 - e0) - res.b - tc;
        return res;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [65:0] v);
        logic signed [COORD_W-1:0] res;
        if (v > 66'sh7FFFFFFF) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -66'sh80000000) begin
            res = 32'sh80000000;
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

    // control
    logic [4:0]       r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_k;
    logic             r_built;
    logic             r_axis;
    logic             r_lerp;

    // build datapath
    logic signed [COORD_W-1:0] r_raw [2][4];
    t_coef                     r_coef [2];
    logic [IDX_W-1:0]          r_n;
    logic [FAC_W-1:0]          r_nn;
    logic [FAC_W-1:0]          r_fac;
    logic [3*IDX_W-1:0]        r_n3;
    logic signed [NUM_W-1:0]   r_acc;
    logic [2*LEN_W:0]          r_sq;
    logic [TOT_W-1:0]          r_total;

    // shared datapath
    logic                      r_neg;
    logic [NUM_W-1:0]          r_mag;
    logic [LEN_W-1:0]          r_den;
    logic signed [NUM_W-1:0]   r_qs;
    logic [LEN_W-1:0]          r_len;
    logic signed [COORD_W-1:0] r_prev [2];
    logic signed [COORD_W-1:0] r_cur [2];
    logic signed [COORD_W-1:0] r_res [2];

    // lookup datapath
    logic [31:0]      r_dist;
    logic [TOT_W-1:0] r_end;
    logic [LEN_W-1:0] r_off;
    logic [6:0]       r_seg;

    // memory
    t_entry           r_mem [MAX_POINTS];
    t_entry           r_rdata;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_entry           mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    // output register
    logic                      r_out_valid;
    logic signed [COORD_W-1:0] r_o_x;
    logic signed [COORD_W-1:0] r_o_y;
    logic [6:0]                r_o_seg;
    logic [31:0]               r_o_tot;

    // units
    logic             div_done;
    logic [NUM_W-1:0] div_q;
    logic [LEN_W-1:0] div_r;
    logic             sqrt_done;
    logic [LEN_W-1:0] sqrt_root;

    // combinational helpers
    t_coef                          cf;
    logic signed [COEF_W+FAC_W:0]   mac_prod;
    logic signed [NUM_W-1:0]        mul_i;
    logic signed [COORD_W:0]        dd;
    logic [COORD_W-1:0]             dabs;
    logic [2*LEN_W-1:0]             dsq;
    logic [NUM_W-1:0]               q1;
    logic signed [COORD_W-1:0]      base;
    logic signed [COORD_W-1:0]      sat_v;
    logic [TOT_W-1:0]               end_n;
    logic [CNT_W-1:0]               k_inc;
    logic [CNT_W:0]                 pc_ext;
    logic [CNT_W-1:0]               cnt_in;
    logic                           in_acc;
    logic                           out_acc;
    logic                           out_free;

    assign cf       = r_coef[r_axis];
    assign mac_prod = (r_state == S_MAC_B) ? cf.b * $signed({1'b0, r_nn})
                    : (r_state == S_MAC_C) ? cf.c * $signed({1'b0, r_fac})
                    : cf.d * $signed({1'b0, r_fac});
    assign mul_i    = r_acc * $signed({1'b0, r_k[IDX_W-1:0]});
    assign dd       = (r_state == S_L_MUL) ? (COORD_W+1)'(r_cur[r_axis]) - (COORD_W+1)'(r_prev[r_axis])
                                           : (COORD_W+1)'(r_prev[r_axis]) - (COORD_W+1)'(r_cur[r_axis]);
    assign dabs     = dd[COORD_W] ? COORD_W'(-dd) : dd[COORD_W-1:0];
    assign dsq      = (r_state == S_L_MUL) ? dabs * r_off : dabs * dabs;
    assign q1       = div_q + NUM_W'(div_r >= (r_den - div_r));
    assign base     = r_lerp ? r_prev[r_axis] : cf.a0;
    assign sat_v    = sat32(66'(base) + 66'(r_qs));
    assign end_n    = r_end + TOT_W'(r_rdata.len);
    assign k_inc    = r_k + 1'b1;
    assign pc_ext   = (CNT_W+1)'(i_req.point_count);
    assign cnt_in   = (pc_ext > (CNT_W+1)'(MAX_POINTS - 1)) ? CNT_W'(MAX_POINTS)
                                                             : pc_ext[CNT_W-1:0];
    assign in_acc   = i_req.valid && i_req.ready;
    assign out_acc  = r_out_valid && o_rsp.ready;
    assign out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready = (r_state == S_IDLE);

    // memory ports
    assign mem_we    = (r_state == S_COEF) || (r_state == S_WRITE);
    assign mem_waddr = (r_state == S_COEF) ? '0 : r_k[IDX_W-1:0];
    assign mem_wdata = (r_state == S_COEF) ? t_entry'{x: r_raw[0][0], y: r_raw[1][0], len: '0}
                                           : t_entry'{x: r_cur[0], y: r_cur[1], len: r_len};
    assign mem_raddr = (r_state == S_I_RD0) ? '0 : r_k[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    cbz_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIV),
        .i_dividend (r_mag),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    cbz_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SQRT && !r_sq[2*LEN_W]),
        .i_value (r_sq[2*LEN_W-1:0]),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // the result state reloads the register itself
            if (out_acc && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_k    <= CNT_W'(1);
                        r_axis <= 1'b0;
                        r_lerp <= i_req.op;
                        r_dist <= i_req.distance;
                        r_end  <= '0;
                        r_raw[0][0] <= i_req.p0_x;
                        r_raw[1][0] <= i_req.p0_y;
                        r_raw[0][1] <= i_req.p1_x;
                        r_raw[1][1] <= i_req.p1_y;
                        r_raw[0][2] <= i_req.p2_x;
                        r_raw[1][2] <= i_req.p2_y;
                        r_raw[0][3] <= i_req.p3_x;
                        r_raw[1][3] <= i_req.p3_y;
                        if (i_req.op == OP_BUILD) begin
                            r_cnt   <= cnt_in;
                            r_state <= S_COEF;
                        end else begin
                            r_state <= S_I_RD0;
                        end
                    end
                end
                S_COEF: begin
                    r_coef[0] <= mk_coef(r_raw[0][0], r_raw[0][1], r_raw[0][2], r_raw[0][3]);
                    r_coef[1] <= mk_coef(r_raw[1][0], r_raw[1][1], r_raw[1][2], r_raw[1][3]);
                    r_n       <= IDX_W'(r_cnt - 1'b1);
                    r_nn      <= FAC_W'(IDX_W'(r_cnt - 1'b1) * IDX_W'(r_cnt - 1'b1));
                    r_n3      <= (3*IDX_W)'(IDX_W'(r_cnt - 1'b1) * IDX_W'(r_cnt - 1'b1)
                                            * IDX_W'(r_cnt - 1'b1));
                    r_built   <= 1'b1;
                    r_prev[0] <= r_raw[0][0];
                    r_prev[1] <= r_raw[1][0];
                    r_total   <= '0;
                    r_res[0]  <= '0;
                    r_res[1]  <= '0;
                    r_seg     <= '0;
                    r_state   <= (r_cnt <= CNT_W'(1)) ? S_OUT : S_MAC_B;
                end
                S_MAC_B: begin
                    r_acc   <= NUM_W'(mac_prod);
                    r_fac   <= FAC_W'(r_k[IDX_W-1:0] * r_n);
                    r_state <= S_MAC_C;
                end
                S_MAC_C: begin
                    r_acc   <= r_acc + NUM_W'(mac_prod);
                    r_fac   <= FAC_W'(r_k[IDX_W-1:0] * r_k[IDX_W-1:0]);
                    r_state <= S_MAC_D;
                end
                S_MAC_D: begin
                    r_acc   <= r_acc + NUM_W'(mac_prod);
                    r_state <= S_MUL_I;
                end
                S_MUL_I: begin
                    r_acc   <= mul_i;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_neg   <= r_acc[NUM_W-1];
                    r_mag   <= r_acc[NUM_W-1] ? NUM_W'(-r_acc) : r_acc;
                    r_den   <= LEN_W'(r_n3);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_state <= S_DIV_W;
                end
                S_DIV_W: begin
                    if (div_done) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    r_qs    <= r_neg ? NUM_W'(-q1) : q1;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (r_lerp) begin
                        r_res[r_axis] <= sat_v;
                        if (!r_axis) begin
                            r_axis  <= 1'b1;
                            r_state <= S_L_MUL;
                        end else begin
                            r_seg   <= 7'(r_k);
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_cur[r_axis] <= sat_v;
                        if (!r_axis) begin
                            r_axis  <= 1'b1;
                            r_state <= S_MAC_B;
                        end else begin
                            r_axis  <= 1'b0;
                            r_state <= S_SQ_X;
                        end
                    end
                end
                S_SQ_X: begin
                    r_sq    <= (2*LEN_W+1)'(dsq);
                    r_axis  <= 1'b1;
                    r_state <= S_SQ_Y;
                end
                S_SQ_Y: begin
                    r_sq    <= r_sq + (2*LEN_W+1)'(dsq);
                    r_axis  <= 1'b0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    // sum of squares past 64 bits saturates the length
                    if (r_sq[2*LEN_W]) begin
                        r_len   <= '1;
                        r_state <= S_WRITE;
                    end else begin
                        r_state <= S_SQRT_W;
                    end
                end
                S_SQRT_W: begin
                    if (sqrt_done) begin
                        r_len   <= sqrt_root;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_total   <= r_total + TOT_W'(r_len);
                    r_prev[0] <= r_cur[0];
                    r_prev[1] <= r_cur[1];
                    r_k       <= k_inc;
                    r_state   <= (k_inc == r_cnt) ? S_OUT : S_MAC_B;
                end
                S_I_RD0: begin
                    r_state <= S_I_PREV;
                end
                S_I_PREV: begin
                    r_prev[0] <= r_built ? r_rdata.x : '0;
                    r_prev[1] <= r_built ? r_rdata.y : '0;
                    if (r_cnt <= CNT_W'(1)) begin
                        r_res[0] <= r_built ? r_rdata.x : '0;
                        r_res[1] <= r_built ? r_rdata.y : '0;
                        r_seg    <= 7'(r_k);
                        r_state  <= S_OUT;
                    end else begin
                        r_state  <= S_I_RD;
                    end
                end
                S_I_RD: begin
                    r_state <= S_I_CHK;
                end
                S_I_CHK: begin
                    if (end_n > TOT_W'(r_dist)) begin
                        r_off   <= LEN_W'(TOT_W'(r_dist) - r_end);
                        r_len   <= r_rdata.len;
                        r_cur[0] <= r_rdata.x;
                        r_cur[1] <= r_rdata.y;
                        r_axis  <= 1'b0;
                        r_state <= S_L_MUL;
                    end else begin
                        r_prev[0] <= r_rdata.x;
                        r_prev[1] <= r_rdata.y;
                        r_end     <= end_n;
                        r_k       <= k_inc;
                        if (k_inc == r_cnt) begin
                            // past the end: last stored point
                            r_res[0] <= r_rdata.x;
                            r_res[1] <= r_rdata.y;
                            r_seg    <= 7'(k_inc);
                            r_state  <= S_OUT;
                        end else begin
                            r_state  <= S_I_RD;
                        end
                    end
                end
                S_L_MUL: begin
                    r_neg   <= dd[COORD_W];
                    r_mag   <= dsq;
                    r_den   <= r_len;
                    r_state <= S_DIV;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_x       <= r_res[0];
                        r_o_y       <= r_res[1];
                        r_o_seg     <= r_seg;
                        r_o_tot     <= (r_lerp || (|r_total[TOT_W-1:LEN_W])) ?
                                       {32{!r_lerp}} : r_total[LEN_W-1:0];
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.pos_x         = r_o_x;
    assign o_rsp.pos_y         = r_o_y;
    assign o_rsp.segment_index = r_o_seg;
    assign o_rsp.total_length  = r_o_tot;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_POINTS))
        else $error("stored count beyond memory depth");

    a_build_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.total_length != '0) |-> (o_rsp.segment_index == '0))
        else $error("build word carries a segment index");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("output loaded outside the result state");

    a_mem_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (r_k < r_cnt) && (r_k != '0))
        else $error("curve point written outside the built range");
endmodule

@@ test/curve_sample_and_arc_follow_test.sv @@
// Self-checking bench for curve_sample_and_arc_follow: directed table, then random
// build/lookup sequences checked against an in-bench curve and arc predictor.
// Depends on cbz_pkg, cbz_if and the block itself.
module curve_sample_and_arc_follow_test;
    import cbz_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int RAND_ITEMS  = 560;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [6:0]         seg;
        logic [31:0]        tot;
    } rsp_word_t;

    typedef struct {
        logic               op;
        logic [31:0]        pts [8];  // p0x p0y p1x p1y p2x p2y p3x p3y
        logic [7:0]         cnt;
        logic [31:0]        travel;
        bit                 typed;
        rsp_word_t          want;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cbz_in_if  req ();
    cbz_out_if rsp ();

    curve_sample_and_arc_follow dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req.sink),
        .o_rsp   (rsp.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state: sampled curve and segment lengths
    longint          crv_x [MAX_POINTS];
    longint          crv_y [MAX_POINTS];
    longint unsigned crv_len [MAX_POINTS];
    int unsigned     crv_cnt;
    longint unsigned crv_total;

    rsp_word_t pending_rsp [$];
    stim_row_t dir_tab [$];
    int  send_idle_pct, recv_stall_pct;
    int  errors, cycles, n_build, n_interp, n_past_end, n_big;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // one axis of the sampled polynomial, rounded to nearest, ties away from zero
    function automatic longint curve_coord(longint a0, longint a1, longint a2, longint a3,
                                           longint i, longint n);
        longint a, b, c, d, num, q;
        longint unsigned m, den, r;
        a   = 3 * a1 + a0;
        b   = (a - a0) * 3;
        c   = ((a2 - 3 * a3) - a) * 3 - b;
        d   = ((a2 - a0) - b) - c;
        num = b * i * n * n + c * i * i * n + d * i * i * i;
        den = n * n * n;
        m   = (num < 0) ? -num : num;
        q   = m / den;
        r   = m % den;
        if (r >= den - r) q++;
        return sat32(a0 + ((num < 0) ? -q : q));
    endfunction

    function automatic longint unsigned seg_len(longint ax, longint ay, longint bx, longint by);
        longint unsigned ux, uy, sx, sy, v, res, bt;
        ux = (ax > bx) ? ax - bx : bx - ax;
        uy = (ay > by) ? ay - by : by - ay;
        sx = ux * ux;
        sy = uy * uy;
        if (sx > 64'hFFFF_FFFF_FFFF_FFFF - sy) return 64'hFFFF_FFFF;
        v   = sx + sy;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v  -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic longint lerp_coord(longint prev, longint curr,
                                          longint unsigned off, longint unsigned len);
        longint unsigned m, p, q, r;
        m = (curr < prev) ? prev - curr : curr - prev;
        p = m * off;
        q = p / len;
        r = p % len;
        if (r >= len - r) q++;
        return sat32(prev + ((curr < prev) ? -longint'(q) : longint'(q)));
    endfunction

    function automatic rsp_word_t predict_word(stim_row_t w);
        rsp_word_t o;
        longint x0, y0, n;
        longint unsigned endd, len, off, tot;
        int unsigned c, k;
        o = '{x: 0, y: 0, seg: 0, tot: 0};
        if (w.op == OP_BUILD) begin
            c = w.cnt;
            if (c > MAX_POINTS - 1) c = MAX_POINTS;
            crv_cnt    = c;
            x0         = longint'($signed(w.pts[0]));
            y0         = longint'($signed(w.pts[1]));
            crv_x[0]   = x0;
            crv_y[0]   = y0;
            crv_len[0] = 0;
            tot        = 0;
            n          = c - 1;
            for (k = 1; k < c; k++) begin
                crv_x[k] = curve_coord(x0, $signed(w.pts[2]), $signed(w.pts[4]),
                                       $signed(w.pts[6]), k, n);
                crv_y[k] = curve_coord(y0, $signed(w.pts[3]), $signed(w.pts[5]),
                                       $signed(w.pts[7]), k, n);
                crv_len[k] = seg_len(crv_x[k-1], crv_y[k-1], crv_x[k], crv_y[k]);
                tot += crv_len[k];
            end
            if (tot > 64'hFFFF_FFFF) tot = 64'hFFFF_FFFF;
            crv_total = tot;
            o.tot = tot[31:0];
        end else begin
            endd = 0;
            for (k = 1; k < crv_cnt; k++) begin
                endd += crv_len[k];
                if (endd > w.travel) break;
            end
            if (k < crv_cnt) begin
                len = crv_len[k];
                off = w.travel - (endd - len);
                o.x = lerp_coord(crv_x[k-1], crv_x[k], off, len);
                o.y = lerp_coord(crv_y[k-1], crv_y[k], off, len);
            end else begin
                o.x = crv_x[k-1];
                o.y = crv_y[k-1];
                n_past_end++;
            end
            o.seg = k[6:0];
        end
        return o;
    endfunction

    task automatic add_row(logic op, logic [31:0] p0x, logic [31:0] p0y, logic [31:0] p1x,
                           logic [31:0] p1y, logic [31:0] p2x, logic [31:0] p2y,
                           logic [31:0] p3x, logic [31:0] p3y, logic [7:0] cnt,
                           logic [31:0] travel, bit typed, rsp_word_t want);
        stim_row_t r;
        r.op     = op;
        r.pts    = '{p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y};
        r.cnt    = cnt;
        r.travel = travel;
        r.typed  = typed;
        r.want   = want;
        dir_tab.push_back(r);
    endtask

    // drive one request word and hold it until accepted
    task automatic send_word(stim_row_t w);
        rsp_word_t p;
        while ($urandom_range(99) < send_idle_pct) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid       <= 1'b1;
        req.op          <= w.op;
        req.p0_x        <= w.pts[0];
        req.p0_y        <= w.pts[1];
        req.p1_x        <= w.pts[2];
        req.p1_y        <= w.pts[3];
        req.p2_x        <= w.pts[4];
        req.p2_y        <= w.pts[5];
        req.p3_x        <= w.pts[6];
        req.p3_y        <= w.pts[7];
        req.point_count <= w.cnt;
        req.distance    <= w.travel;
        do @(posedge i_clk); while (!req.ready);
        p = predict_word(w);
        if (w.typed) p = w.want;
        pending_rsp.push_back(p);
        if (w.op == OP_BUILD) n_build++;
        else n_interp++;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0:       return $urandom_range(2047) - 1024;
            1:       return $urandom_range(32'h0020_0000) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] rand_count();
        if ($urandom_range(99) < 2) return $urandom_range(60, 255);
        return $urandom_range(0, 10);
    endfunction

    // response side: check and random stall
    always @(posedge i_clk) begin
        rsp_word_t e;
        cycles <= cycles + 1;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected word x=%h y=%h seg=%0d tot=%h", $time,
                         rsp.pos_x, rsp.pos_y, rsp.segment_index, rsp.total_length);
                errors++;
            end else begin
                e = pending_rsp.pop_front();
                if (rsp.pos_x !== e.x) begin
                    $display("%0t: pos_x expected %h actual %h", $time, e.x, rsp.pos_x);
                    errors++;
                end
                if (rsp.pos_y !== e.y) begin
                    $display("%0t: pos_y expected %h actual %h", $time, e.y, rsp.pos_y);
                    errors++;
                end
                if (rsp.segment_index !== e.seg) begin
                    $display("%0t: segment_index expected %0d actual %0d", $time, e.seg,
                             rsp.segment_index);
                    errors++;
                end
                if (rsp.total_length !== e.tot) begin
                    $display("%0t: total_length expected %h actual %h", $time, e.tot,
                             rsp.total_length);
                    errors++;
                end
            end
        end
        rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles,
                     pending_rsp.size());
            $display("curve_sample_and_arc_follow verification failed");
            $finish;
        end
    end

    initial begin
        stim_row_t w;
        rsp_word_t z;
        int i, nint, done;
        errors = 0; cycles = 0; n_build = 0; n_interp = 0; n_past_end = 0; n_big = 0;
        crv_cnt = 0; crv_total = 0;
        for (i = 0; i < MAX_POINTS; i++) begin
            crv_x[i] = 0; crv_y[i] = 0; crv_len[i] = 0;
        end
        send_idle_pct  = 26;
        recv_stall_pct = 83;
        req.valid = 1'b0; req.op = OP_BUILD; req.point_count = '0; req.distance = '0;
        req.p0_x = '0; req.p0_y = '0; req.p1_x = '0; req.p1_y = '0;
        req.p2_x = '0; req.p2_y = '0; req.p3_x = '0; req.p3_y = '0;
        rsp.ready = 1'b0;
        z = '{x: 0, y: 0, seg: 0, tot: 0};

        // empty curve after reset, then zero/one point curves, then a straight line
        add_row(OP_INTERP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0, 1, '{0, 0, 1, 0});
        add_row(OP_INTERP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, '{0, 0, 1, 0});
        add_row(OP_BUILD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1, z);
        add_row(OP_INTERP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5, 1,
                '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0});
        add_row(OP_BUILD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0, 1, z);
        add_row(OP_INTERP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                '{32'h8000_0000, 32'h8000_0000, 1, 0});
        add_row(OP_BUILD, 0, 0, 0, 0, 32'h000A_0000, 0, 0, 0, 2, 0, 1, '{0, 0, 0, 655360});
        add_row(OP_INTERP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 327680, 1, '{327680, 0, 1, 0});
        add_row(OP_INTERP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 655360, 1, '{655360, 0, 2, 0});
        // saturated count, extreme control values, saturated total, then counts near the memory depth
        add_row(OP_BUILD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 255, 0, 0, z);
        add_row(OP_INTERP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, z);
        add_row(OP_INTERP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 0, z);
        add_row(OP_INTERP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, z);
        add_row(OP_BUILD, 32'h0001_0000, 32'hFFFF_0000, 32'h0003_8000, 32'h0000_4000,
                32'h0050_0000, 32'h0020_0000, 32'hFFF0_0000, 32'h0001_2345, 63, 0, 0, z);
        add_row(OP_INTERP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0010_0000, 0, z);
        add_row(OP_INTERP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0000_8001, 0, z);
        add_row(OP_BUILD, 32'h1234_5678, 32'h8765_4321, 32'h0000_FFFF, 32'hFFFF_0001,
                32'h0100_0000, 32'hFF00_0000, 32'h7FFF_FFFF, 32'h8000_0000, 64, 0, 0, z);
        add_row(OP_INTERP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h2000_0000, 0, z);
        add_row(OP_BUILD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 65, 0, 0, z);
        add_row(OP_INTERP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0001, 0, z);
        add_row(OP_BUILD, 32'h0000_0100, 32'h0000_0200, 32'h0000_0010, 32'hFFFF_FFF0,
                32'h0003_0000, 32'h0004_0000, 32'h0000_1000, 32'h0000_2000, 3, 0, 0, z);
        add_row(OP_INTERP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 0, z);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) send_word(dir_tab[k]);

        // random part: a build followed by a run of lookups, with some noise
        done = 0;
        while (done < RAND_ITEMS) begin
            if (done >= RAND_ITEMS / 3) begin
                send_idle_pct  = 83;
                recv_stall_pct = 26;
            end
            if (done >= 2 * RAND_ITEMS / 3) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            if (done >= RAND_ITEMS / 2 && done < RAND_ITEMS / 2 + 8) begin
                req.valid <= 1'b0;
                while (pending_rsp.size() != 0) @(posedge i_clk);
            end
            w.op = ($urandom_range(9) == 0) ? OP_INTERP : OP_BUILD;
            for (i = 0; i < 8; i++) w.pts[i] = rand_coord();
            w.cnt    = rand_count();
            w.travel = $urandom;
            w.typed  = 0;
            if (w.op == OP_BUILD && w.cnt > 9) n_big++;
            send_word(w);
            done++;
            nint = $urandom_range(1, 6);
            for (i = 0; i < nint; i++) begin
                w.op = OP_INTERP;
                for (int j = 0; j < 8; j++) w.pts[j] = $urandom;
                w.cnt = $urandom;
                case ($urandom_range(3))
                    0:       w.travel = $urandom;
                    1:       w.travel = crv_total[31:0] + $urandom_range(3);
                    default: w.travel = (crv_total == 0) ? 32'h0 :
                                        $urandom_range(crv_total[31:0]);
                endcase
                send_word(w);
                done++;
            end
        end
        req.valid <= 1'b0;

        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);

        $display("covered %0d builds (%0d with long counts) and %0d lookups", n_build, n_big,
                 n_interp);
        $display("%0d lookups landed at or past the curve end", n_past_end);
        if (errors == 0) begin
            $display("curve_sample_and_arc_follow verification clean");
        end else begin
            $display("curve_sample_and_arc_follow verification failed");
        end
        $finish;
    end
endmodule
